// File: rtl/core/midcd_pkg.sv
package midcd_pkg;

   // Fixed field widths of the scan and event channels.
   localparam int SAMPLE_W = 8;
   localparam int CHAN_W   = 3;
   localparam int HIST_W   = 8;

   // Only the first MAX_LANES channels have a sample bit in a scan.
   localparam int MAX_LANES = 8;

   // Defaults for the top-level parameters.
   localparam int CHANNELS_DEFAULT       = 8;
   localparam int STABLE_SAMPLES_DEFAULT = 5;

   typedef logic [SAMPLE_W-1:0] samples_type;
   typedef logic [CHAN_W-1:0]   channel_type;
   typedef logic [HIST_W-1:0]   history_type;

endpackage

// File: rtl/core/midcd_if.sv
interface midcd_req_if;
   logic                   valid;
   logic                   ready;
   midcd_pkg::samples_type samples;

   modport source (output valid, output samples, input ready);
   modport sink   (input valid, input samples, output ready);
endinterface

interface midcd_rsp_if;
   logic                   valid;
   logic                   ready;
   midcd_pkg::channel_type channel;
   logic                   level;
   logic                   last;

   modport source (output valid, output channel, output level, output last, input ready);
   modport sink   (input valid, input channel, input level, input last, output ready);
endinterface

// File: rtl/core/multi_input_debounce_change_detect.sv
// Multi-channel shift-register debouncer with change detection. Each request
// carries one scan: one raw sample bit per input. On acceptance every channel
// shifts its sample into an 8-bit history, and a channel whose history goes
// from the rise pattern's "almost stable" byte to its "stable" byte while its
// debounced level is low rises; the mirror-image byte pair with the level high
// makes it fall. The full byte is compared, so a change is only recognised on
// that exact pattern. Each change flips the debounced level and yields one
// event (channel, new level), delivered in ascending channel order with the
// final event of the scan marked by last. A scan without changes leaves
// nothing behind, so such scans may arrive every cycle. A scan with N
// changes, at most 8, occupies the event serialiser until all N events have
// left it (one event per cycle when the consumer keeps ready high); the next
// scan is accepted in the same cycle as the previous scan's final event leaves
// the serialiser. Channels at index 8 and above never receive a sample bit and
// therefore never change; they hold no storage.
module multi_input_debounce_change_detect #(
   parameter int CHANNELS       = midcd_pkg::CHANNELS_DEFAULT,
   parameter int STABLE_SAMPLES = midcd_pkg::STABLE_SAMPLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   midcd_req_if.sink   req_bus,
   midcd_rsp_if.source rsp_bus
);

   // Channels that can actually see a sample bit.
   localparam int LANES   = (CHANNELS < midcd_pkg::MAX_LANES) ? CHANNELS
                                                              : midcd_pkg::MAX_LANES;
   localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int HIST_W  = midcd_pkg::HIST_W;

   // Rise: the history was STABLE_SAMPLES-1 ones and becomes STABLE_SAMPLES
   // ones. Fall: the byte-wise complements of both.
   localparam logic [HIST_W-1:0] RISE_OLD = HIST_W'((1 << (STABLE_SAMPLES - 1)) - 1);
   localparam logic [HIST_W-1:0] RISE_NEW = HIST_W'((1 << STABLE_SAMPLES) - 1);
   localparam logic [HIST_W-1:0] FALL_OLD = ~RISE_OLD;
   localparam logic [HIST_W-1:0] FALL_NEW = ~RISE_NEW;

   // Per-channel sample history and debounced level.
   midcd_pkg::history_type hist_ff [LANES];
   midcd_pkg::history_type hist_in [LANES];
   logic [LANES-1:0]       deb_ff;
   logic [LANES-1:0]       deb_in;

   // Events of the scan being serialised: which channels changed, and the
   // new level of every channel.
   logic [LANES-1:0]       pend_mask_ff;
   logic [LANES-1:0]       pend_mask_in;
   logic [LANES-1:0]       pend_level_ff;
   logic [LANES-1:0]       pend_level_in;

   // Output register holding one event.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   midcd_pkg::channel_type rsp_channel_ff;
   midcd_pkg::channel_type rsp_channel_in;
   logic                   rsp_level_ff;
   logic                   rsp_level_in;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;

   logic [LANES-1:0]       change;
   logic [LANES-1:0]       rest;
   logic [LANE_W-1:0]      sel;
   logic                   req_take;
   logic                   out_free;
   logic                   move;

   // Change detection for the scan on offer.
   always_comb begin
      midcd_pkg::history_type nxt;
      for (int k = 0; k < LANES; k++) begin
         nxt       = {hist_ff[k][HIST_W-2:0], req_bus.samples[k]};
         change[k] = ((hist_ff[k] == RISE_OLD) && (nxt == RISE_NEW) && !deb_ff[k]) ||
                     ((hist_ff[k] == FALL_OLD) && (nxt == FALL_NEW) &&  deb_ff[k]);
         hist_in[k] = req_take ? nxt : hist_ff[k];
      end
   end

   // Lowest pending channel goes out first.
   always_comb begin
      sel = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (pend_mask_ff[k]) begin
            sel = LANE_W'(k);
         end
      end
   end

   assign rest     = pend_mask_ff & (pend_mask_ff - LANES'(1));
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign move     = out_free && (pend_mask_ff != '0);

   // A new scan may enter once the current one has nothing left after this
   // cycle's transfer.
   assign req_bus.ready = (pend_mask_ff == '0) || (move && (rest == '0));
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      deb_in        = req_take ? (deb_ff ^ change) : deb_ff;
      pend_level_in = req_take ? (deb_ff ^ change) : pend_level_ff;
      if (req_take) begin
         pend_mask_in = change;
      end else if (move) begin
         pend_mask_in = rest;
      end else begin
         pend_mask_in = pend_mask_ff;
      end

      rsp_channel_in = rsp_channel_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_last_in    = rsp_last_ff;
      if (move) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = midcd_pkg::CHAN_W'(sel);
         rsp_level_in   = pend_level_ff[sel];
         rsp_last_in    = (rest == '0);
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANES; k++) begin
            hist_ff[k] <= '0;
         end
         deb_ff       <= '0;
         pend_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < LANES; k++) begin
            hist_ff[k] <= hist_in[k];
         end
         deb_ff       <= deb_in;
         pend_mask_ff <= pend_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_level_ff  <= pend_level_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.channel = rsp_channel_ff;
   assign rsp_bus.level   = rsp_level_ff;
   assign rsp_bus.last    = rsp_last_ff;

endmodule

// File: rtl/core/midcd_chk.sv
module midcd_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input midcd_pkg::channel_type rsp_channel,
   input logic                   rsp_level,
   input logic                   rsp_last
);

   // Channel and last flag of the previous delivered event.
   logic                   seen_ff;
   logic                   prev_last_ff;
   midcd_pkg::channel_type prev_chan_ff;
   logic                   rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         prev_last_ff <= 1'b1;
         prev_chan_ff <= '0;
      end else if (rsp_take) begin
         seen_ff      <= 1'b1;
         prev_last_ff <= rsp_last;
         prev_chan_ff <= rsp_channel;
      end
   end

   // An event waiting for the consumer keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel) &&
                                  $stable(rsp_level) && $stable(rsp_last))
      else $error("event changed while stalled");

   // Within one scan the events come in strictly ascending channel order.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && !prev_last_ff |-> rsp_channel > prev_chan_ff)
      else $error("events of a scan out of channel order");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event pending after reset");

   // Nothing is queued straight after reset, so a scan can be taken at once.
   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready)
      else $error("scan refused straight after reset");

endmodule

bind multi_input_debounce_change_detect midcd_chk u_midcd_chk (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_channel (rsp_bus.channel),
   .rsp_level   (rsp_bus.level),
   .rsp_last    (rsp_bus.last)
);

// File: verif/midcd_event_checker.sv
`timescale 1ns / 100ps

module midcd_event_checker #(
   parameter int CHANNELS       = midcd_pkg::CHANNELS_DEFAULT,
   parameter int STABLE_SAMPLES = midcd_pkg::STABLE_SAMPLES_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   midcd_req_if  req_mon,
   midcd_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    awaited_count
);

   localparam midcd_pkg::history_type RISE_NEW =
      midcd_pkg::history_type'((1 << STABLE_SAMPLES) - 1);
   localparam midcd_pkg::history_type RISE_OLD =
      midcd_pkg::history_type'((1 << (STABLE_SAMPLES - 1)) - 1);
   localparam midcd_pkg::history_type FALL_NEW = ~RISE_NEW;
   localparam midcd_pkg::history_type FALL_OLD = ~RISE_OLD;
   localparam int                     SHOWN_MISMATCHES = 10;

   typedef struct packed {
      midcd_pkg::channel_type channel;
      logic                   level;
      logic                   last;
   } change_event_type;

   midcd_pkg::history_type sample_history [CHANNELS];
   logic                   stable_level   [CHANNELS];
   change_event_type       awaited_events [$];

   // Shifts one scan into every channel and queues the changes it causes.
   task automatic debounce_scan(input midcd_pkg::samples_type scan);
      change_event_type       scan_events [midcd_pkg::MAX_LANES];
      midcd_pkg::history_type old_hist;
      midcd_pkg::history_type new_hist;
      logic                   bit_in;
      int                     found;
      found = 0;
      for (int k = 0; k < CHANNELS; k++) begin
         bit_in   = (k < midcd_pkg::MAX_LANES) ? scan[k] : 1'b0;
         old_hist = sample_history[k];
         new_hist = midcd_pkg::history_type'({old_hist, bit_in});
         if ((old_hist == RISE_OLD) && (new_hist == RISE_NEW) && !stable_level[k]) begin
            stable_level[k] = 1'b1;
            scan_events[found] = '{channel: midcd_pkg::channel_type'(k), level: 1'b1,
                                   last: 1'b0};
            found++;
         end else if ((old_hist == FALL_OLD) && (new_hist == FALL_NEW) && stable_level[k]) begin
            stable_level[k] = 1'b0;
            scan_events[found] = '{channel: midcd_pkg::channel_type'(k), level: 1'b0,
                                   last: 1'b0};
            found++;
         end
         sample_history[k] = new_hist;
      end
      for (int i = 0; i < found; i++) begin
         scan_events[i].last = (i == found - 1);
         awaited_events.push_back(scan_events[i]);
      end
   endtask

   always @(posedge clock) begin
      change_event_type want;
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            sample_history[k] = '0;
            stable_level[k]   = 1'b0;
         end
         awaited_events.delete();
      end else begin
         // The request is handled first, so an event that leaves in the same
         // cycle still finds the expectations of all older scans ahead of it.
         if (req_mon.valid && req_mon.ready) begin
            debounce_scan(req_mon.samples);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES) begin
                  $display("%0t: unexpected event channel %0d level %0b last %0b", $realtime,
                           rsp_mon.channel, rsp_mon.level, rsp_mon.last);
               end
            end else begin
               want = awaited_events.pop_front();
               if ((rsp_mon.channel !== want.channel) || (rsp_mon.level !== want.level) ||
                   (rsp_mon.last !== want.last)) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MISMATCHES) begin
                     $display("%0t: expected channel %0d level %0b last %0b, got %0d %0b %0b",
                              $realtime, want.channel, want.level, want.last,
                              rsp_mon.channel, rsp_mon.level, rsp_mon.last);
                  end
               end
            end
         end
      end
      awaited_count = awaited_events.size();
   end

endmodule

// File: verif/multi_input_debounce_change_detect_tb.sv
`timescale 1ns / 100ps

module multi_input_debounce_change_detect_tb;

   // Length of the single long stall on the event side, in cycles.
   localparam int HOLD_CYCLES = 400;
   // Scans per randomised phase; four phases give roughly 370 scans.
   localparam int PHASE_SCANS = 92;

   logic clock = 1'b0;
   logic reset = 1'b1;

   midcd_req_if req_bus ();
   midcd_rsp_if rsp_bus ();

   int mismatch_count;
   int awaited_count;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;

   // The stimulus asks for the long stall; the receiver process owns the count.
   bit want_hold  = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left  = 0;

   // Per-channel state of the well-formed level generator: the level being
   // held and how many more scans it is held for.
   midcd_pkg::samples_type held_level = '0;
   int                     run_left [midcd_pkg::MAX_LANES];

   multi_input_debounce_change_detect #(
      .CHANNELS       (midcd_pkg::CHANNELS_DEFAULT),
      .STABLE_SAMPLES (midcd_pkg::STABLE_SAMPLES_DEFAULT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   midcd_event_checker #(
      .CHANNELS       (midcd_pkg::CHANNELS_DEFAULT),
      .STABLE_SAMPLES (midcd_pkg::STABLE_SAMPLES_DEFAULT)
   ) event_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   always #1 clock = ~clock;

   // The receiver decides its ready at every falling edge. When the long
   // stall has been asked for, it holds ready low through that stall whilst the
   // sender keeps offering scans, so that the serialiser fills and the block
   // has to refuse requests.
   always @(negedge clock) begin
      if (want_hold && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // A generous bound on the whole run; the slowest correct run needs a
   // small fraction of it.
   initial begin
      #400000;
      $display("multi_input_debounce_change_detect test failed");
      $finish;
   end

   // Offers one scan. It is entered just after a rising edge, changes the
   // inputs only at falling edges, and returns at the rising edge at which
   // the request is taken. Valid is lowered only when an idle cycle is
   // inserted, so it is never lowered and raised in the same time step.
   task automatic send_scan(input midcd_pkg::samples_type scan);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid   <= 1'b0;
         req_bus.samples <= midcd_pkg::samples_type'($urandom);
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.samples <= scan;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // One randomised phase. Most scans come from the run-length generator:
   // each channel holds its level for a run, usually long enough to pass the
   // debouncer and occasionally a short bounce. Some of those scans carry a
   // one-bit glitch, and a few are pure noise.
   task automatic run_phase(input int sender_idle, input int receiver_stall);
      midcd_pkg::samples_type scan;
      int                     roll;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      for (int n = 0; n < PHASE_SCANS; n++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            scan = midcd_pkg::samples_type'($urandom);
         end else begin
            for (int k = 0; k < midcd_pkg::MAX_LANES; k++) begin
               if (run_left[k] == 0) begin
                  held_level[k] = ~held_level[k];
                  run_left[k]   = ($urandom_range(99) < 80) ? $urandom_range(5, 12)
                                                            : $urandom_range(1, 4);
               end
               run_left[k]--;
            end
            scan = held_level;
            if (roll < 16) begin
               scan = scan ^ midcd_pkg::samples_type'(
                         1 << $urandom_range(midcd_pkg::MAX_LANES - 1));
            end
         end
         send_scan(scan);
      end
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.samples = '0;
      for (int k = 0; k < midcd_pkg::MAX_LANES; k++) begin
         run_left[k] = 0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Four all-high scans bring every history to the
      // almost-stable rise pattern, and the fifth makes all eight channels
      // rise at once: the largest burst a scan can cause.
      repeat (5) send_scan(8'hFF);
      // Five all-low scans do the same for the fall.
      repeat (5) send_scan(8'h00);
      // Clear the histories, then take the outermost channels towards a rise.
      // Only channel 7 completes it; channel 0 bounces back one sample short
      // and must stay low.
      repeat (3) send_scan(8'h00);
      repeat (4) send_scan(8'h81);
      send_scan(8'h80);
      // Scans that cause no change at all still shift the histories.
      send_scan(8'hAA);
      send_scan(8'h55);
      send_scan(8'h3C);
      send_scan(8'h00);

      // The long stall falls in the phase without idling, where the sender
      // pushes hardest against the full serialiser.
      want_hold = 1'b1;
      run_phase(0, 0);
      run_phase(86, 0);
      run_phase(0, 86);
      run_phase(26, 26);

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Let every awaited event arrive, then keep watching in case the block
      // emits anything it should not.
      wait (awaited_count == 0);
      repeat (20) @(posedge clock);

      if ((mismatch_count == 0) && (awaited_count == 0)) begin
         $display("multi_input_debounce_change_detect test passed");
      end else begin
         $display("multi_input_debounce_change_detect test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/midcd_pkg.sv
rtl/core/midcd_if.sv
rtl/core/multi_input_debounce_change_detect.sv
rtl/core/midcd_chk.sv
verif/midcd_event_checker.sv
verif/multi_input_debounce_change_detect_tb.sv
